>>> rtl/core/d2q_pkg.sv
// Shared types, constants and arithmetic helpers for the D2Q9 collision pipeline.
package d2q_pkg;

    localparam int FRAC_BITS = 24;
    localparam int DW = 32;
    localparam int RW = 26;
    localparam int PW = 64 - FRAC_BITS;
    localparam int EW = PW + 5;
    localparam int CW = (FRAC_BITS + 3 > RW + 1) ? FRAC_BITS + 3 : RW + 1;
    localparam int PIPE_DEPTH = 9;
    localparam int F_LAST = PIPE_DEPTH - 1;

    localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic [RW-1:0] RELAX_RESET = RW'(ONE);
    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

    // Constant divider by 36: numerator split at DV_SPL, reciprocal exact below 2^DV_ZW.
    localparam int DVW = 38;
    localparam int DV_SPL = 19;
    localparam int DV_HW = DVW - DV_SPL;
    localparam int DV_ZW = 25;
    localparam int DV_MW = 26;
    localparam int DV_S = 31;
    localparam int DV_QAW = 14;
    localparam int DV_RW = DV_ZW - DV_SPL;
    localparam int DV_OFS_Q = 8192;
    localparam int DV_OFS = 36 * DV_OFS_Q;
    localparam logic [DV_MW-1:0] DV_M = 26'd59652324;

    localparam logic [3:0] DIR_REST = 4'd0;
    localparam logic [3:0] DIR_E = 4'd1;
    localparam logic [3:0] DIR_N = 4'd2;
    localparam logic [3:0] DIR_W = 4'd3;
    localparam logic [3:0] DIR_S = 4'd4;
    localparam logic [3:0] DIR_NE = 4'd5;
    localparam logic [3:0] DIR_NW = 4'd6;
    localparam logic [3:0] DIR_SW = 4'd7;
    localparam logic [3:0] DIR_SE = 4'd8;

    typedef struct packed {
        logic signed [1:0] cx;
        logic signed [1:0] cy;
        logic [2:0] ksh;
        logic ok;
    } dir_t;

    typedef struct packed {
        logic a;
        logic b;
    } div_en_t;

    // Weight k/36 with k = 16, 4, 1 is applied as a left shift by ksh.
    function automatic dir_t dir_info(input logic [3:0] d);
        dir_t r;
        case (d)
            DIR_REST: r = '{cx: 2'sd0, cy: 2'sd0, ksh: 3'd4, ok: 1'b1};
            DIR_E: r = '{cx: 2'sd1, cy: 2'sd0, ksh: 3'd2, ok: 1'b1};
            DIR_N: r = '{cx: 2'sd0, cy: 2'sd1, ksh: 3'd2, ok: 1'b1};
            DIR_W: r = '{cx: -2'sd1, cy: 2'sd0, ksh: 3'd2, ok: 1'b1};
            DIR_S: r = '{cx: 2'sd0, cy: -2'sd1, ksh: 3'd2, ok: 1'b1};
            DIR_NE: r = '{cx: 2'sd1, cy: 2'sd1, ksh: 3'd0, ok: 1'b1};
            DIR_NW: r = '{cx: -2'sd1, cy: 2'sd1, ksh: 3'd0, ok: 1'b1};
            DIR_SW: r = '{cx: -2'sd1, cy: -2'sd1, ksh: 3'd0, ok: 1'b1};
            DIR_SE: r = '{cx: 2'sd1, cy: -2'sd1, ksh: 3'd0, ok: 1'b1};
            default: r = '{cx: 2'sd0, cy: 2'sd0, ksh: 3'd0, ok: 1'b0};
        endcase
        return r;
    endfunction

    function automatic logic signed [DW+1:0] unit_mul(input logic signed [1:0] c,
                                                      input logic signed [DW-1:0] x);
        logic signed [DW+1:0] r;
        if (c == 2'sd1) begin
            r = (DW+2)'(x);
        end else if (c == -2'sd1) begin
            r = -(DW+2)'(x);
        end else begin
            r = '0;
        end
        return r;
    endfunction

    // Round to nearest, ties toward plus infinity.
    function automatic logic signed [PW-1:0] rnd(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = (p + HALF) >>> FRAC_BITS;
        return s[PW-1:0];
    endfunction

    function automatic logic signed [DW-1:0] sat32(input logic signed [63:0] v);
        logic signed [DW-1:0] r;
        if (v > SAT_MAX) begin
            r = SAT_MAX[DW-1:0];
        end else if (v < SAT_MIN) begin
            r = SAT_MIN[DW-1:0];
        end else begin
            r = v[DW-1:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/core/d2q_div36.sv
// Two-stage floor division of a signed numerator by 36 using reciprocal multiplies.
module d2q_div36 (
    input  logic                              aclk,
    input  d2q_pkg::div_en_t                  en,
    input  logic signed [d2q_pkg::DVW-1:0]    num,
    output logic signed [d2q_pkg::DW-1:0]     quo
);

    logic signed [d2q_pkg::DV_HW-1:0]                hi;
    logic [d2q_pkg::DV_ZW-1:0]                       z;
    logic [d2q_pkg::DV_ZW+d2q_pkg::DV_MW-1:0]        pz;
    logic [d2q_pkg::DV_QAW:0]                        qa_raw;
    logic signed [d2q_pkg::DV_QAW-1:0]               qa;
    logic signed [d2q_pkg::DV_QAW-1:0]               qa_reg;
    logic signed [d2q_pkg::DV_HW-1:0]                hi_reg;
    logic [d2q_pkg::DV_SPL-1:0]                      lo_reg;
    logic [d2q_pkg::DV_RW-1:0]                       ra;
    logic [d2q_pkg::DV_ZW-1:0]                       y;
    logic [d2q_pkg::DV_ZW+d2q_pkg::DV_MW-1:0]        py;
    logic [d2q_pkg::DV_SPL-1:0]                      qb;
    logic signed [d2q_pkg::DW-1:0]                   quo_next;
    logic signed [d2q_pkg::DW-1:0]                   quo_reg;

    // The upper part is offset by a multiple of 36 so the reciprocal sees a
    // nonnegative value; the offset is taken back out of the quotient.
    assign hi = num[d2q_pkg::DVW-1:d2q_pkg::DV_SPL];
    assign z = d2q_pkg::DV_ZW'(32'(hi) + d2q_pkg::DV_OFS);
    assign pz = z * d2q_pkg::DV_M;
    assign qa_raw = pz[d2q_pkg::DV_S +: d2q_pkg::DV_QAW+1];
    assign qa = d2q_pkg::DV_QAW'(16'(qa_raw) - 16'(d2q_pkg::DV_OFS_Q));

    always_ff @(posedge aclk) begin
        if (en.a) begin
            qa_reg <= qa;
            hi_reg <= hi;
            lo_reg <= num[d2q_pkg::DV_SPL-1:0];
        end
    end

    // The remainder of the upper part joins the lower bits; that quotient
    // is below 2^DV_SPL and simply fills the low bits.
    assign ra = d2q_pkg::DV_RW'(32'(hi_reg) - 32'(qa_reg) * 36);
    assign y = {ra, lo_reg};
    assign py = y * d2q_pkg::DV_M;
    assign qb = py[d2q_pkg::DV_S +: d2q_pkg::DV_SPL];
    assign quo_next = $signed(d2q_pkg::DW'({qa_reg, qb}));

    always_ff @(posedge aclk) begin
        if (en.b) begin
            quo_reg <= quo_next;
        end
    end

    assign quo = quo_reg;

endmodule

>>> rtl/core/d2q9_bgk_guo_collision.sv
// D2Q9 BGK collision with Guo forcing: one population per request, nine-stage pipeline.
//
// Usage: each request on the s_ channel carries one population of one cell with
// that cell's density, velocity, body force, fluid flag and direction index.
// The m_ channel returns the relaxed population, one result per request, in order.
// The relaxation rate is written through the cfg_ port, which is always ready;
// write it only while no request is in flight.
// An accepted request raises m_valid once it has passed through every stage register.
// Throughput is one request per cycle while m_ready is high; the variable multiplies are
// spread so that no stage chains two of them, and the division by 36 takes two stages.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles are squeezed out while the receiver stalls and s_ready stays high
// until every stage holds a request. A stall loses and repeats nothing.
// Synchronous reset clears all valid bits and sets the relaxation rate to 1.0.
// Non-fluid cells and direction codes above 8 pass the population unchanged.
module d2q9_bgk_guo_collision (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [d2q_pkg::RW-1:0]          cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [3:0]                      s_direction,
    input  logic                            s_is_fluid,
    input  logic signed [d2q_pkg::DW-1:0]   s_population,
    input  logic signed [d2q_pkg::DW-1:0]   s_density,
    input  logic signed [d2q_pkg::DW-1:0]   s_vel_x,
    input  logic signed [d2q_pkg::DW-1:0]   s_vel_y,
    input  logic signed [d2q_pkg::DW-1:0]   s_force_x,
    input  logic signed [d2q_pkg::DW-1:0]   s_force_y,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [d2q_pkg::DW-1:0]   m_new_population
);

    localparam int N = d2q_pkg::PIPE_DEPTH;
    localparam int DW = d2q_pkg::DW;
    localparam int PW = d2q_pkg::PW;

    logic [d2q_pkg::RW-1:0]     relax_rate_reg;
    logic [N+1:1]               en;
    logic [N:1]                 vld_reg;
    logic [N:1]                 vld_in;
    logic signed [DW-1:0]       f_reg [1:d2q_pkg::F_LAST];
    logic                       pass_reg [1:d2q_pkg::F_LAST];
    d2q_pkg::div_en_t           div_en;

    // Stage 1
    d2q_pkg::dir_t              s_dir;
    logic signed [DW-1:0]       eu0;
    logic signed [1:0]          cx1_reg, cy1_reg;
    logic [2:0]                 ksh1_reg;
    logic signed [DW-1:0]       rho1_reg, ux1_reg, uy1_reg, fx1_reg, fy1_reg, eu1_reg;
    // Stage 2
    logic signed [63:0]         m_uxux, m_uyuy, m_eueu;
    logic signed [DW-1:0]       tx, ty;
    logic signed [PW-1:0]       pux2_reg, puy2_reg, peu2_reg;
    logic signed [DW-1:0]       tx2_reg, ty2_reg, eu2_reg, rho2_reg, fx2_reg, fy2_reg;
    logic [2:0]                 ksh2_reg;
    // Stage 3
    logic signed [63:0]         m_txfx, m_tyfy;
    logic signed [DW-1:0]       uu;
    logic signed [63:0]         epart;
    logic signed [DW-1:0]       uu3_reg, rho3_reg;
    logic signed [d2q_pkg::EW-1:0] ep3_reg;
    logic signed [PW-1:0]       ptx3_reg, pty3_reg;
    logic [2:0]                 ksh3_reg;
    // Stage 4
    logic signed [DW-1:0]       b_val, g_val;
    logic signed [DW-1:0]       b4_reg, g4_reg, rho4_reg;
    logic [2:0]                 ksh4_reg;
    // Stage 5
    logic signed [d2q_pkg::RW:0]   w_s;
    logic signed [d2q_pkg::CW-1:0] wc2, wc1;
    logic signed [63:0]         m_rhob, m_hg;
    logic signed [DW-1:0]       t5_reg, h5_reg;
    logic [2:0]                 ksh5_reg;
    // Stages 6 and 7
    logic signed [d2q_pkg::DVW-1:0] num_feq, num_fq;
    logic signed [DW-1:0]       feq7, fq7;
    // Stage 8
    logic signed [63:0]         m_cf, m_wf;
    logic signed [PW-1:0]       pf8_reg, pw8_reg;
    logic signed [DW-1:0]       fq8_reg;
    // Stage 9
    logic signed [DW-1:0]       out_next, out_reg;

    // Configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            relax_rate_reg <= d2q_pkg::RELAX_RESET;
        end else if (cfg_valid) begin
            relax_rate_reg <= cfg_data;
        end
    end

    // Flow control: a stage loads when it is empty or its content moves on.
    always_comb begin
        en[N+1] = m_ready;
        for (int i = N; i >= 1; i--) begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign vld_in = {vld_reg[N-1:1], s_valid};
    assign s_ready = en[1];
    assign m_valid = vld_reg[N];
    assign div_en.a = en[6];
    assign div_en.b = en[7];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = 1; i <= N; i++) begin
                if (en[i]) begin
                    vld_reg[i] <= vld_in[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            f_reg[1] <= s_population;
            pass_reg[1] <= !s_is_fluid || !s_dir.ok;
        end
        for (int i = 2; i <= d2q_pkg::F_LAST; i++) begin
            if (en[i]) begin
                f_reg[i] <= f_reg[i-1];
                pass_reg[i] <= pass_reg[i-1];
            end
        end
    end

    // Stage 1: direction decode and e.u
    assign s_dir = d2q_pkg::dir_info(s_direction);
    assign eu0 = d2q_pkg::sat32(64'(d2q_pkg::unit_mul(s_dir.cx, s_vel_x))
                                + 64'(d2q_pkg::unit_mul(s_dir.cy, s_vel_y)));

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            cx1_reg <= s_dir.cx;
            cy1_reg <= s_dir.cy;
            ksh1_reg <= s_dir.ksh;
            rho1_reg <= s_density;
            ux1_reg <= s_vel_x;
            uy1_reg <= s_vel_y;
            fx1_reg <= s_force_x;
            fy1_reg <= s_force_y;
            eu1_reg <= eu0;
        end
    end

    // Stage 2: squares of the velocity and of e.u, forcing direction terms
    assign m_uxux = ux1_reg * ux1_reg;
    assign m_uyuy = uy1_reg * uy1_reg;
    assign m_eueu = eu1_reg * eu1_reg;
    assign tx = d2q_pkg::sat32(64'sd3 * (64'(cx1_reg) * d2q_pkg::ONE - 64'(ux1_reg))
                               + 64'sd9 * 64'(d2q_pkg::unit_mul(cx1_reg, eu1_reg)));
    assign ty = d2q_pkg::sat32(64'sd3 * (64'(cy1_reg) * d2q_pkg::ONE - 64'(uy1_reg))
                               + 64'sd9 * 64'(d2q_pkg::unit_mul(cy1_reg, eu1_reg)));

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            pux2_reg <= d2q_pkg::rnd(m_uxux);
            puy2_reg <= d2q_pkg::rnd(m_uyuy);
            peu2_reg <= d2q_pkg::rnd(m_eueu);
            tx2_reg <= tx;
            ty2_reg <= ty;
            eu2_reg <= eu1_reg;
            rho2_reg <= rho1_reg;
            fx2_reg <= fx1_reg;
            fy2_reg <= fy1_reg;
            ksh2_reg <= ksh1_reg;
        end
    end

    // Stage 3: u.u, the equilibrium bracket without u.u, forcing products
    assign uu = d2q_pkg::sat32(64'(pux2_reg) + 64'(puy2_reg));
    assign epart = 64'sd2 * d2q_pkg::ONE + 64'sd6 * 64'(eu2_reg)
                   + 64'sd9 * 64'(peu2_reg) + 64'sd1;
    assign m_txfx = tx2_reg * fx2_reg;
    assign m_tyfy = ty2_reg * fy2_reg;

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            uu3_reg <= uu;
            ep3_reg <= d2q_pkg::EW'(epart);
            ptx3_reg <= d2q_pkg::rnd(m_txfx);
            pty3_reg <= d2q_pkg::rnd(m_tyfy);
            rho3_reg <= rho2_reg;
            ksh3_reg <= ksh2_reg;
        end
    end

    // Stage 4: the halved bracket b and the force projection g
    assign b_val = d2q_pkg::sat32((64'(ep3_reg) - 64'sd3 * 64'(uu3_reg)) >>> 1);
    assign g_val = d2q_pkg::sat32(64'(ptx3_reg) + 64'(pty3_reg));

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            b4_reg <= b_val;
            g4_reg <= g_val;
            rho4_reg <= rho3_reg;
            ksh4_reg <= ksh3_reg;
        end
    end

    // Stage 5: rho*b and (2 - w)*g
    assign w_s = $signed({1'b0, relax_rate_reg});
    assign wc2 = d2q_pkg::CW'(64'sd2 * d2q_pkg::ONE - 64'(w_s));
    assign wc1 = d2q_pkg::CW'(d2q_pkg::ONE - 64'(w_s));
    assign m_rhob = rho4_reg * b4_reg;
    assign m_hg = wc2 * g4_reg;

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            t5_reg <= d2q_pkg::sat32(64'(d2q_pkg::rnd(m_rhob)));
            h5_reg <= d2q_pkg::sat32(64'(d2q_pkg::rnd(m_hg)));
            ksh5_reg <= ksh4_reg;
        end
    end

    // Stages 6 and 7: feq = floor((k*t + 18)/36), Fq = floor((k*h + 36)/72)
    assign num_feq = (d2q_pkg::DVW'(t5_reg) <<< ksh5_reg) + d2q_pkg::DVW'(18);
    assign num_fq = ((d2q_pkg::DVW'(h5_reg) <<< ksh5_reg) + d2q_pkg::DVW'(36)) >>> 1;

    d2q_div36 u_div_feq (
        .aclk (aclk),
        .en   (div_en),
        .num  (num_feq),
        .quo  (feq7)
    );

    d2q_div36 u_div_fq (
        .aclk (aclk),
        .en   (div_en),
        .num  (num_fq),
        .quo  (fq7)
    );

    // Stage 8: relaxation products
    assign m_cf = wc1 * f_reg[7];
    assign m_wf = w_s * feq7;

    always_ff @(posedge aclk) begin
        if (en[8]) begin
            pf8_reg <= d2q_pkg::rnd(m_cf);
            pw8_reg <= d2q_pkg::rnd(m_wf);
            fq8_reg <= fq7;
        end
    end

    // Stage 9: final sum and output register
    assign out_next = pass_reg[8] ? f_reg[8]
                    : d2q_pkg::sat32(64'(pf8_reg) + 64'(pw8_reg) + 64'(fq8_reg));

    always_ff @(posedge aclk) begin
        if (en[9]) begin
            out_reg <= out_next;
        end
    end

    assign m_new_population = out_reg;

endmodule

>>> rtl/core/d2q_checker.sv
// Port-level assertions for the D2Q9 collision block and their bind.
module d2q_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic signed [d2q_pkg::DW-1:0]   m_new_population
);

    localparam int CNTW = $clog2(d2q_pkg::PIPE_DEPTH + 2);

    logic [CNTW-1:0] cnt_reg;
    logic [CNTW-1:0] cnt_next;

    // Requests accepted whose results have not yet been taken.
    assign cnt_next = cnt_reg + CNTW'(s_valid && s_ready) - CNTW'(m_valid && m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_new_population))
        else $error("stalled result changed or dropped");

    a_ready_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input blocked while the receiver is ready");

    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> cnt_reg != '0)
        else $error("result without an outstanding request");

    a_capacity: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNTW'(d2q_pkg::PIPE_DEPTH))
        else $error("more requests in flight than pipeline stages");

endmodule

bind d2q9_bgk_guo_collision d2q_checker u_d2q_checker (.*);
